@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define PLF_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("plf assertion failed");

`define PLF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("plf assertion failed");

`define PLF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("plf assertion failed");

`else

`define PLF_ASSERT(lbl, expr)
`define PLF_ASSERT_IMP(lbl, ante, cons)
`define PLF_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

@@ src/plf_pkg.sv @@
// ----------------------------------------------------------------------------
// plf_pkg
// Types and constants of the parameter list key finder.
// ----------------------------------------------------------------------------
package plf_pkg;

  localparam int KEY_BYTES  = 16;
  localparam int HALF_BYTES = KEY_BYTES / 2;
  localparam int IDX_W      = 5;
  localparam int SKIP_W     = 17;
  localparam int CFG_IDX_W  = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_PRESENT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_BIG_ENDIAN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXTRA_PID          = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_HASH_PID       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SENTINEL_PID       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BIG_ENDIAN_CODE    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_LITTLE_ENDIAN_CODE = 3'd6;

  typedef enum logic [2:0] {
    ST_KEY_HASH  = 3'd0,
    ST_SEARCH    = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_BAD_ENCAP = 3'd3,
    ST_TRUNCATED = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_ENTRY  = 3'd1,
    PH_KEY    = 3'd2,
    PH_SKIP   = 3'd3,
    PH_DONE   = 3'd4
  } phase_t;

  typedef struct packed {
    logic        header_present;
    logic        default_big_endian;
    logic [15:0] extra_pid;
    logic [15:0] key_hash_pid;
    logic [15:0] sentinel_pid;
    logic [7:0]  big_endian_code;
    logic [7:0]  little_endian_code;
  } plf_cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } plf_word_t;

endpackage

@@ src/plf_if.sv @@
// ----------------------------------------------------------------------------
// plf_if
// Valid/ready channels of the key finder: byte input, result, config write.
// ----------------------------------------------------------------------------
interface plf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;
  modport source (output valid, data_byte, final_byte, input ready);
  modport sink (input valid, data_byte, final_byte, output ready);
endinterface

interface plf_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [63:0] key_upper;
  logic [63:0] key_lower;
  logic [7:0]  encapsulation_code;
  modport source (output valid, status, key_upper, key_lower, encapsulation_code,
                  input ready);
  modport sink (input valid, status, key_upper, key_lower, encapsulation_code,
                output ready);
endinterface

interface plf_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ src/plf_front.sv @@
// ----------------------------------------------------------------------------
// plf_front
// Accepts payload words and holds them in a two-entry queue for the parser.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module plf_front
  import plf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  plf_in_if.sink     in_ch,
  output logic       q_valid,
  input  logic       q_ready,
  output plf_word_t  q_word
);

  plf_word_t  mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  assign in_ch.ready = (cnt_r != 2'd2);
  assign q_valid     = (cnt_r != 2'd0);
  assign q_word      = mem_r[rd_ptr_r];
  assign push        = in_ch.valid && in_ch.ready;
  assign pop         = q_valid && q_ready;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= '{data_byte: in_ch.data_byte, final_byte: in_ch.final_byte};
    end
  end

  `PLF_ASSERT(a_cnt_range, cnt_r <= 2'd2)
  `PLF_ASSERT(a_ptr_match, (wr_ptr_r ^ rd_ptr_r) == (cnt_r == 2'd1))

endmodule

@@ src/plf_parser.sv @@
// ----------------------------------------------------------------------------
// plf_parser
// Walks the parameter list one byte a cycle while out_ch is free, and registers one result per payload.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module plf_parser
  import plf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  plf_cfg_t   cfg,
  input  logic       q_valid,
  output logic       q_ready,
  input  plf_word_t  q_word,
  plf_out_if.source  out_ch
);

  localparam logic [IDX_W-1:0] IDX_ENTRY_END = IDX_W'(4);
  localparam logic [IDX_W-1:0] IDX_KEY_END   = IDX_W'(KEY_BYTES);
  localparam logic [IDX_W-1:0] IDX_HALF      = IDX_W'(HALF_BYTES);

  phase_t              phase_r, phase_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [23:0]         eh_r, eh_nxt;
  logic [SKIP_W-1:0]   skip_r, skip_nxt;
  logic [63:0]         key0_r, key0_nxt, key1_r, key1_nxt;
  logic                be_r, be_nxt;
  logic                ms_r, ms_nxt;
  logic [7:0]          encap_r, encap_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [2:0]          status_r, status_nxt;
  logic [63:0]         kup_r, kup_nxt, klo_r, klo_nxt;
  logic [7:0]          ocode_r, ocode_nxt;

  logic                consume;
  logic [7:0]          b;
  logic                fin;
  logic [IDX_W-1:0]    idx_inc;
  logic [31:0]         eh_full;
  logic                be_eff;
  logic [15:0]         pid, len;
  logic [SKIP_W-1:0]   pad_len;

  // entry header step, shared by the entry phase and the headerless start
  phase_t              ent_phase;
  logic [IDX_W-1:0]    ent_idx;
  logic [23:0]         ent_eh;
  logic [SKIP_W-1:0]   ent_skip;
  logic                ent_ms;
  logic                ent_clr;
  logic                ent_res;
  status_t             ent_status;

  logic                res;
  status_t             res_status;
  logic                with_key;

  assign q_ready = !out_valid_r || out_ch.ready;
  assign consume = q_valid && q_ready;
  assign b       = q_word.data_byte;
  assign fin     = q_word.final_byte;
  assign idx_inc = idx_r + IDX_W'(1);
  assign eh_full = {eh_r, b};
  assign be_eff  = (phase_r == PH_HEADER) ? cfg.default_big_endian : be_r;
  assign pid     = be_eff ? eh_full[31:16] : {eh_full[23:16], eh_full[31:24]};
  assign len     = be_eff ? eh_full[15:0] : {eh_full[7:0], eh_full[15:8]};
  assign pad_len = ({1'b0, len} + SKIP_W'(3)) & ~SKIP_W'(3);

  always_comb begin
    ent_phase  = PH_ENTRY;
    ent_idx    = idx_inc;
    ent_eh     = eh_full[23:0];
    ent_skip   = skip_r;
    ent_ms     = ms_r;
    ent_clr    = 1'b0;
    ent_res    = 1'b0;
    ent_status = ST_NOT_FOUND;
    if (idx_inc >= IDX_ENTRY_END) begin
      ent_idx = '0;
      ent_eh  = '0;
      priority if (pid == cfg.sentinel_pid) begin
        ent_res = 1'b1;
      end else if (pid == cfg.key_hash_pid || pid == cfg.extra_pid) begin
        ent_ms    = (pid != cfg.key_hash_pid);
        ent_clr   = 1'b1;
        ent_phase = PH_KEY;
      end else begin
        ent_skip  = pad_len;
        ent_phase = (pad_len == '0) ? PH_ENTRY : PH_SKIP;
      end
    end
    if (fin && !ent_res) begin
      ent_res    = 1'b1;
      ent_status = (ent_phase == PH_KEY) ? ST_TRUNCATED : ST_NOT_FOUND;
    end
  end

  always_comb begin
    phase_nxt  = phase_r;
    idx_nxt    = idx_r;
    eh_nxt     = eh_r;
    skip_nxt   = skip_r;
    key0_nxt   = key0_r;
    key1_nxt   = key1_r;
    be_nxt     = be_r;
    ms_nxt     = ms_r;
    encap_nxt  = encap_r;
    res        = 1'b0;
    res_status = ST_NOT_FOUND;
    with_key   = 1'b0;

    if (consume) begin
      unique case (phase_r)
        PH_HEADER: begin
          if (idx_r == '0 && !cfg.header_present) begin
            be_nxt     = cfg.default_big_endian;
            phase_nxt  = ent_phase;
            idx_nxt    = ent_idx;
            eh_nxt     = ent_eh;
            skip_nxt   = ent_skip;
            ms_nxt     = ent_ms;
            res        = ent_res;
            res_status = ent_status;
            if (ent_clr) begin
              key0_nxt = '0;
              key1_nxt = '0;
            end
          end else begin
            if (idx_r == IDX_W'(1)) begin
              encap_nxt = b;
              priority if (b == cfg.big_endian_code) begin
                be_nxt = 1'b1;
              end else if (b == cfg.little_endian_code) begin
                be_nxt = 1'b0;
              end else begin
                res        = 1'b1;
                res_status = ST_BAD_ENCAP;
              end
            end
            idx_nxt = idx_inc;
            if (idx_r >= IDX_W'(3)) begin
              phase_nxt = PH_ENTRY;
              idx_nxt   = '0;
            end
            if (fin && !res) begin
              res        = 1'b1;
              res_status = (idx_r == '0) ? ST_BAD_ENCAP : ST_NOT_FOUND;
            end
          end
        end
        PH_ENTRY: begin
          phase_nxt  = ent_phase;
          idx_nxt    = ent_idx;
          eh_nxt     = ent_eh;
          skip_nxt   = ent_skip;
          ms_nxt     = ent_ms;
          res        = ent_res;
          res_status = ent_status;
          if (ent_clr) begin
            key0_nxt = '0;
            key1_nxt = '0;
          end
        end
        PH_KEY: begin
          if (idx_r < IDX_HALF) begin
            key0_nxt = {key0_r[55:0], b};
          end else begin
            key1_nxt = {key1_r[55:0], b};
          end
          idx_nxt = idx_inc;
          if (idx_inc >= IDX_KEY_END) begin
            res        = 1'b1;
            res_status = ms_r ? ST_SEARCH : ST_KEY_HASH;
            with_key   = 1'b1;
          end else if (fin) begin
            res        = 1'b1;
            res_status = ST_TRUNCATED;
          end
        end
        PH_SKIP: begin
          skip_nxt = (skip_r != '0) ? skip_r - SKIP_W'(1) : skip_r;
          if (skip_nxt == '0) begin
            phase_nxt = PH_ENTRY;
            idx_nxt   = '0;
            eh_nxt    = '0;
          end
          if (fin) begin
            res        = 1'b1;
            res_status = ST_NOT_FOUND;
          end
        end
        default: begin
          // done: drop bytes until the end of the payload
        end
      endcase
    end

    // result word from the updated state, before any restart
    status_nxt    = status_r;
    kup_nxt       = kup_r;
    klo_nxt       = klo_r;
    ocode_nxt     = ocode_r;
    out_valid_nxt = out_ch.ready ? 1'b0 : out_valid_r;
    if (consume && res) begin
      out_valid_nxt = 1'b1;
      status_nxt    = res_status;
      kup_nxt       = with_key ? key0_nxt : '0;
      klo_nxt       = with_key ? key1_nxt : '0;
      ocode_nxt     = encap_nxt;
      phase_nxt     = PH_DONE;
    end

    // restart on the last byte of a payload
    if (consume && fin) begin
      phase_nxt = PH_HEADER;
      idx_nxt   = '0;
      eh_nxt    = '0;
      skip_nxt  = '0;
      key0_nxt  = '0;
      key1_nxt  = '0;
      be_nxt    = 1'b0;
      ms_nxt    = 1'b0;
      encap_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HEADER;
      idx_r       <= '0;
      eh_r        <= '0;
      skip_r      <= '0;
      key0_r      <= '0;
      key1_r      <= '0;
      be_r        <= 1'b0;
      ms_r        <= 1'b0;
      encap_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      idx_r       <= idx_nxt;
      eh_r        <= eh_nxt;
      skip_r      <= skip_nxt;
      key0_r      <= key0_nxt;
      key1_r      <= key1_nxt;
      be_r        <= be_nxt;
      ms_r        <= ms_nxt;
      encap_r     <= encap_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    kup_r    <= kup_nxt;
    klo_r    <= klo_nxt;
    ocode_r  <= ocode_nxt;
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.status             = status_r;
  assign out_ch.key_upper          = kup_r;
  assign out_ch.key_lower          = klo_r;
  assign out_ch.encapsulation_code = ocode_r;

  `PLF_ASSERT_IMP(a_key_idx, phase_r == PH_KEY, idx_r < IDX_KEY_END)
  `PLF_ASSERT_IMP(a_entry_idx, phase_r == PH_ENTRY, idx_r < IDX_ENTRY_END)
  `PLF_ASSERT_IMP(a_skip_nonzero, phase_r == PH_SKIP, skip_r != '0)
  `PLF_ASSERT_NXT(a_result_done, consume && res && !fin, phase_r == PH_DONE)

endmodule

@@ src/parameter_list_key_finder_unit.sv @@
// ----------------------------------------------------------------------------
// parameter_list_key_finder_unit: one status per payload, one byte per cycle
// while out_ch is free. A byte is parsed when the parser takes it from the
// queue; its status word is registered for out_ch. A held status word backs up.
// Synchronous active-low reset restores register defaults and empties the queue.
// ----------------------------------------------------------------------------
module parameter_list_key_finder_unit
  import plf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  plf_cfg_if.sink    cfg_ch,
  plf_in_if.sink     in_ch,
  plf_out_if.source  out_ch
);

  localparam plf_cfg_t CFG_RESET = '{
    header_present:     1'b1,
    default_big_endian: 1'b0,
    extra_pid:          16'd80,
    key_hash_pid:       16'd112,
    sentinel_pid:       16'd1,
    big_endian_code:    8'd2,
    little_endian_code: 8'd3
  };

  plf_cfg_t  cfg_r, cfg_nxt;
  logic      q_valid;
  logic      q_ready;
  plf_word_t q_word;

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_HEADER_PRESENT:     cfg_nxt.header_present     = cfg_ch.data[0];
        CFG_DEFAULT_BIG_ENDIAN: cfg_nxt.default_big_endian = cfg_ch.data[0];
        CFG_EXTRA_PID:          cfg_nxt.extra_pid          = cfg_ch.data;
        CFG_KEY_HASH_PID:       cfg_nxt.key_hash_pid       = cfg_ch.data;
        CFG_SENTINEL_PID:       cfg_nxt.sentinel_pid       = cfg_ch.data;
        CFG_BIG_ENDIAN_CODE:    cfg_nxt.big_endian_code    = cfg_ch.data[7:0];
        CFG_LITTLE_ENDIAN_CODE: cfg_nxt.little_endian_code = cfg_ch.data[7:0];
        default: begin
          // unknown index: drop the word
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  plf_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_word  (q_word)
  );

  plf_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_word  (q_word),
    .out_ch  (out_ch)
  );

endmodule
